>>> design/ymfr_pkg.sv
// Shared types and constants for the YMODEM frame receiver.
`default_nettype none
package ymfr_pkg;
	localparam logic [7:0] CODE_SOH = 8'h01;
	localparam logic [7:0] CODE_STX = 8'h02;
	localparam logic [7:0] CODE_EOT = 8'h04;
	localparam logic [10:0] SHORT_PAYLOAD = 11'd128;
	localparam logic [10:0] LONG_PAYLOAD = 11'd1024;
	localparam logic [10:0] FRAME_OVERHEAD = 11'd5;
	localparam logic [10:0] POSITION_MAX = 11'd2047;
	localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

	localparam logic [0:0] CFG_BASE = 1'b0;
	localparam logic [0:0] CFG_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		RPL_NONE = 3'd0, RPL_ACK = 3'd1, RPL_NAK = 3'd2, RPL_START = 3'd3, RPL_END = 3'd4
	} reply_t;

	typedef enum logic [3:0] {
		CLS_DATA = 4'd0, CLS_HEADER = 4'd1, CLS_DUP = 4'd2, CLS_ORDER = 4'd3,
		CLS_CRC = 4'd4, CLS_BADHDR = 4'd5, CLS_SHORT = 4'd6, CLS_COMPL = 4'd7,
		CLS_EOT = 4'd8
	} frame_class_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic stage_valid;
		logic [9:0] stage_offset;
		logic [7:0] stage_byte;
		logic frame_end;
		logic eot;
		logic hdr_err;
		logic short_frame;
		logic compl_err;
		logic crc_err;
		logic long_frame;
		logic [7:0] seq;
	} ev_t;

	typedef struct packed {
		logic stage_valid;
		logic [9:0] stage_offset;
		logic [7:0] stage_byte;
		logic verdict_valid;
		logic [2:0] reply;
		logic [3:0] frame_class;
		logic [10:0] commit_len;
		logic [23:0] commit_address;
		logic [23:0] file_total;
		logic error_limit_hit;
	} res_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

>>> design/ymfr_if.sv
// Valid/ready channel interfaces.
`default_nettype none
interface ymfr_in_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic frame_end;
	modport source(output valid, rx_byte, frame_end, input ready);
	modport sink(input valid, rx_byte, frame_end, output ready);
endinterface

interface ymfr_out_if;
	logic valid;
	logic ready;
	logic stage_valid;
	logic [9:0] stage_offset;
	logic [7:0] stage_byte;
	logic verdict_valid;
	logic [2:0] reply;
	logic [3:0] frame_class;
	logic [10:0] commit_len;
	logic [23:0] commit_address;
	logic [23:0] file_total;
	logic error_limit_hit;
	modport source(output valid, stage_valid, stage_offset, stage_byte, verdict_valid,
		reply, frame_class, commit_len, commit_address, file_total, error_limit_hit,
		input ready);
	modport sink(input valid, stage_valid, stage_offset, stage_byte, verdict_valid,
		reply, frame_class, commit_len, commit_address, file_total, error_limit_hit,
		output ready);
endinterface

interface ymfr_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/ymfr_front.sv
// Front end: frame parsing, CRC and per-frame checks.
`default_nettype none
module ymfr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [7:0] rx_byte,
	input wire logic frame_end,
	input wire logic q_ready,
	output logic in_ready,
	output logic ev_valid,
	output ymfr_pkg::ev_t ev
);
	import ymfr_pkg::*;

	logic [10:0] pos_q;
	logic long_q, herr_q;
	logic [7:0] seq_q, cmp_q, crch_q, crcl_q;
	logic [15:0] crc_q;

	logic fire, lng, herr;
	logic [10:0] size;
	logic [11:0] len;

	assign in_ready = q_ready;
	assign fire = in_valid && q_ready;
	assign ev_valid = fire;

	// Header byte sets payload size for this and later bytes
	always_comb begin
		lng = long_q;
		herr = herr_q;
		if (pos_q == 11'd0) begin
			if (rx_byte == CODE_SOH) begin lng = 1'b0; herr = 1'b0; end
			else if (rx_byte == CODE_STX) begin lng = 1'b1; herr = 1'b0; end
			else herr = 1'b1;
		end
		size = lng ? LONG_PAYLOAD : SHORT_PAYLOAD;
		len = {1'b0, pos_q} + 12'd1;
	end

	logic in_pay;
	logic [15:0] crc_next;
	logic [7:0] crcl_eff;
	assign in_pay = (pos_q >= 11'd3) && !herr && (pos_q < size + 11'd3);
	assign crc_next = crc_update(crc_q, rx_byte);
	// The CRC low byte may be the byte that ends the frame
	assign crcl_eff = (!herr && pos_q == size + 11'd4) ? rx_byte : crcl_q;

	// Classified event
	always_comb begin
		ev = '0;
		ev.stage_valid = in_pay;
		ev.stage_offset = in_pay ? 10'(pos_q - 11'd3) : 10'd0;
		ev.stage_byte = in_pay ? rx_byte : 8'd0;
		ev.frame_end = frame_end;
		ev.eot = (pos_q == 11'd0) && (rx_byte == CODE_EOT);
		ev.hdr_err = herr;
		ev.short_frame = (len < {1'b0, size} + {1'b0, FRAME_OVERHEAD});
		ev.compl_err = (seq_q != ~cmp_q);
		ev.crc_err = (crc_q != {crch_q, crcl_eff});
		ev.long_frame = lng;
		ev.seq = seq_q;
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; long_q <= 1'b0; herr_q <= 1'b0; seq_q <= '0; cmp_q <= '0;
			crc_q <= '0; crch_q <= '0; crcl_q <= '0;
		end else if (fire) begin
			if (frame_end) begin
				pos_q <= '0; long_q <= 1'b0; herr_q <= 1'b0; seq_q <= '0; cmp_q <= '0;
				crc_q <= '0; crch_q <= '0; crcl_q <= '0;
			end else begin
				long_q <= lng;
				herr_q <= herr;
				if (pos_q != POSITION_MAX) pos_q <= pos_q + 11'd1;
				if (pos_q == 11'd1) seq_q <= rx_byte;
				else if (pos_q == 11'd2) cmp_q <= rx_byte;
				else if (pos_q >= 11'd3 && !herr) begin
					if (in_pay) crc_q <= crc_next;
					else if (pos_q == size + 11'd3) crch_q <= rx_byte;
					else if (pos_q == size + 11'd4) crcl_q <= rx_byte;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> design/ymfr_fifo.sv
// Two-entry queue between front and back.
`default_nettype none
module ymfr_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	input wire ymfr_pkg::ev_t wr_data,
	output logic wr_ready,
	output logic rd_valid,
	output ymfr_pkg::ev_t rd_data,
	input wire logic rd_ready
);
	import ymfr_pkg::*;

	ev_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

>>> design/ymfr_back.sv
// Back end: session state, verdicts and output register.
`default_nettype none
module ymfr_back #(
	parameter int ADDRESS_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic ev_valid,
	input wire ymfr_pkg::ev_t ev,
	output logic ev_ready,
	input wire logic [23:0] base_addr,
	input wire logic [2:0] err_limit,
	output logic res_valid,
	output ymfr_pkg::res_t res,
	input wire logic res_ready
);
	import ymfr_pkg::*;

	logic [7:0] exp_q;
	logic hdone_q;
	logic [ADDRESS_BITS-1:0] waddr_q;
	logic [23:0] total_q;
	logic [2:0] oerr_q;
	logic vld_q;
	res_t res_q;

	logic take;
	res_t r;
	logic [10:0] size;
	logic [24:0] tsum;
	logic [ADDRESS_BITS-1:0] base_ext;
	logic [2:0] oerr_n;

	assign ev_ready = !vld_q || res_ready;
	assign take = ev_valid && ev_ready;
	assign res_valid = vld_q;
	assign res = res_q;
	assign size = ev.long_frame ? LONG_PAYLOAD : SHORT_PAYLOAD;
	assign tsum = {1'b0, total_q} + 25'(size);
	assign base_ext = ADDRESS_BITS'({8'd0, base_addr});

	// Verdict
	always_comb begin
		r = '0;
		r.stage_valid = ev.stage_valid;
		r.stage_offset = ev.stage_offset;
		r.stage_byte = ev.stage_byte;
		oerr_n = oerr_q;
		if (ev.frame_end) begin
			r.verdict_valid = 1'b1;
			r.file_total = total_q;
			if (ev.eot) begin r.reply = RPL_END; r.frame_class = CLS_EOT; end
			else if (ev.hdr_err) begin r.reply = RPL_NAK; r.frame_class = CLS_BADHDR; end
			else if (ev.short_frame) begin r.reply = RPL_NAK; r.frame_class = CLS_SHORT; end
			else if (ev.compl_err) begin r.reply = RPL_NAK; r.frame_class = CLS_COMPL; end
			else if (ev.crc_err) begin r.reply = RPL_NAK; r.frame_class = CLS_CRC; end
			else if (ev.seq == exp_q) begin
				if (!hdone_q) begin r.reply = RPL_START; r.frame_class = CLS_HEADER; end
				else begin
					r.reply = RPL_ACK; r.frame_class = CLS_DATA;
					r.commit_len = size;
					r.commit_address = 24'(waddr_q);
					r.file_total = tsum[24] ? TOTAL_MAX : tsum[23:0];
				end
			end else if (ev.seq == exp_q - 8'd1) begin
				r.reply = RPL_ACK; r.frame_class = CLS_DUP;
			end else begin
				r.reply = RPL_NAK; r.frame_class = CLS_ORDER;
				if (oerr_q != 3'd7) oerr_n = oerr_q + 3'd1;
			end
			r.error_limit_hit = (oerr_n >= err_limit);
		end
	end

	// Session state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0; hdone_q <= 1'b0; waddr_q <= ADDRESS_BITS'(24'd4096);
			total_q <= '0; oerr_q <= '0; vld_q <= 1'b0;
		end else begin
			if (take) vld_q <= 1'b1;
			else if (res_ready) vld_q <= 1'b0;
			if (take) begin
				if (r.frame_class == CLS_EOT && r.verdict_valid) begin
					exp_q <= '0; hdone_q <= 1'b0; waddr_q <= base_ext;
					total_q <= '0; oerr_q <= '0;
				end else begin
					oerr_q <= oerr_n;
					if (r.verdict_valid && (r.frame_class == CLS_HEADER ||
							r.frame_class == CLS_DATA)) begin
						exp_q <= exp_q + 8'd1;
						hdone_q <= 1'b1;
						if (r.frame_class == CLS_DATA) begin
							waddr_q <= waddr_q + ADDRESS_BITS'(size);
							total_q <= r.file_total;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= r;
	end
endmodule
`default_nettype wire

>>> design/ymodem_frame_receiver.sv
// Top level of the YMODEM frame receiver.
// Path: a byte's result passes the front (combinational), the queue and the output register.
// Throughput: one byte per cycle while the queue has room; the byte-wide CRC update sets the front's cycle.
// Reset: asynchronous, clears frame and session state; base address 4096, error limit 5.
// Base address writes take effect at the next end of session; a reset restores 4096.
`default_nettype none
module ymodem_frame_receiver #(
	parameter int ADDRESS_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	ymfr_in_if.sink in_ch,
	ymfr_out_if.source out_ch,
	ymfr_cfg_if.sink cfg
);
	import ymfr_pkg::*;

	logic [23:0] base_q;
	logic [2:0] limit_q;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 24'd4096; limit_q <= 3'd5;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BASE: base_q <= cfg.data;
				CFG_LIMIT: limit_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, b_valid, b_ready, r_valid;
	ev_t f_ev, b_ev;
	res_t r;

	ymfr_front u_front (
		.clk, .arst_n, .in_valid(in_ch.valid), .rx_byte(in_ch.rx_byte),
		.frame_end(in_ch.frame_end), .q_ready(f_ready), .in_ready(in_ch.ready),
		.ev_valid(f_valid), .ev(f_ev)
	);

	ymfr_fifo u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_data(f_ev), .wr_ready(f_ready),
		.rd_valid(b_valid), .rd_data(b_ev), .rd_ready(b_ready)
	);

	ymfr_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
		.clk, .arst_n, .ev_valid(b_valid), .ev(b_ev), .ev_ready(b_ready),
		.base_addr(base_q), .err_limit(limit_q), .res_valid(r_valid), .res(r),
		.res_ready(out_ch.ready)
	);

	assign out_ch.valid = r_valid;
	assign out_ch.stage_valid = r.stage_valid;
	assign out_ch.stage_offset = r.stage_offset;
	assign out_ch.stage_byte = r.stage_byte;
	assign out_ch.verdict_valid = r.verdict_valid;
	assign out_ch.reply = r.reply;
	assign out_ch.frame_class = r.frame_class;
	assign out_ch.commit_len = r.commit_len;
	assign out_ch.commit_address = r.commit_address;
	assign out_ch.file_total = r.file_total;
	assign out_ch.error_limit_hit = r.error_limit_hit;

	// A commit always carries a full payload length
	a_commit_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.commit_len != 11'd0 |->
		out_ch.commit_len == SHORT_PAYLOAD || out_ch.commit_len == LONG_PAYLOAD)
		else $error("bad commit length");
	// Staged bytes never come with a verdict of a bad header
	a_stage_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stage_valid |-> out_ch.frame_class != CLS_BADHDR)
		else $error("staged byte in bad-header frame");
	// An unaccepted result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.reply))
		else $error("result dropped");
endmodule
`default_nettype wire

>>> tb/ymfr_tb_pkg.sv
// Frame builders and receiver prediction for the YMODEM frame receiver bench.
package ymfr_tb_pkg;
	import ymfr_pkg::*;

	typedef struct {
		logic [7:0] rx_byte;
		logic frame_end;
	} rx_req_t;

	// Receiver state as the bench tracks it
	typedef struct {
		logic [23:0] base_addr;
		logic [2:0] err_limit;
		logic [10:0] pos;
		logic is_long;
		logic hdr_bad;
		logic [7:0] seq;
		logic [7:0] seq_n;
		logic [15:0] crc;
		logic [7:0] crc_hi;
		logic [7:0] crc_lo;
		logic [7:0] next_seq;
		logic got_header;
		logic [23:0] wr_addr;
		logic [23:0] total;
		logic [2:0] order_errs;
	} rx_state_t;

	// Bitwise CRC16, polynomial 0x1021, MSB first
	function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	function automatic void clear_frame(ref rx_state_t s);
		s.pos = '0;
		s.is_long = 1'b0;
		s.hdr_bad = 1'b0;
		s.seq = '0;
		s.seq_n = '0;
		s.crc = '0;
		s.crc_hi = '0;
		s.crc_lo = '0;
	endfunction

	function automatic void clear_session(ref rx_state_t s);
		s.next_seq = '0;
		s.got_header = 1'b0;
		s.wr_addr = s.base_addr;
		s.total = '0;
		s.order_errs = '0;
	endfunction

	// Advance the receiver by one byte and return the result it must give
	function automatic res_t receive_byte(ref rx_state_t s, input rx_req_t q);
		res_t r;
		logic [10:0] p, size;
		r = '0;
		p = s.pos;
		if (p == 0) begin
			if (q.rx_byte == CODE_SOH) begin
				s.is_long = 1'b0;
				s.hdr_bad = 1'b0;
			end else if (q.rx_byte == CODE_STX) begin
				s.is_long = 1'b1;
				s.hdr_bad = 1'b0;
			end else
				s.hdr_bad = 1'b1;
		end
		size = s.is_long ? LONG_PAYLOAD : SHORT_PAYLOAD;
		if (p == 1)
			s.seq = q.rx_byte;
		else if (p == 2)
			s.seq_n = q.rx_byte;
		else if (p >= 3 && !s.hdr_bad) begin
			if (p < 3 + size) begin
				r.stage_valid = 1'b1;
				r.stage_offset = 10'(p - 3);
				r.stage_byte = q.rx_byte;
				s.crc = crc16_step(s.crc, q.rx_byte);
			end else if (p == 3 + size)
				s.crc_hi = q.rx_byte;
			else if (p == 4 + size)
				s.crc_lo = q.rx_byte;
		end
		if (p < POSITION_MAX)
			s.pos = p + 11'd1;
		if (q.frame_end) begin
			r.verdict_valid = 1'b1;
			if (p == 0 && q.rx_byte == CODE_EOT) begin
				r.reply = RPL_END;
				r.frame_class = CLS_EOT;
			end else if (s.hdr_bad) begin
				r.reply = RPL_NAK;
				r.frame_class = CLS_BADHDR;
			end else if (12'(p) + 1 < 12'(size) + 12'(FRAME_OVERHEAD)) begin
				r.reply = RPL_NAK;
				r.frame_class = CLS_SHORT;
			end else if (s.seq != ~s.seq_n) begin
				r.reply = RPL_NAK;
				r.frame_class = CLS_COMPL;
			end else if (s.crc != {s.crc_hi, s.crc_lo}) begin
				r.reply = RPL_NAK;
				r.frame_class = CLS_CRC;
			end else if (s.seq == s.next_seq) begin
				if (!s.got_header) begin
					s.got_header = 1'b1;
					r.reply = RPL_START;
					r.frame_class = CLS_HEADER;
				end else begin
					r.reply = RPL_ACK;
					r.frame_class = CLS_DATA;
					r.commit_len = size;
					r.commit_address = s.wr_addr;
					s.wr_addr = s.wr_addr + 24'(size);
					if (s.total > TOTAL_MAX - 24'(size))
						s.total = TOTAL_MAX;
					else
						s.total = s.total + 24'(size);
				end
				s.next_seq = s.next_seq + 8'd1;
			end else if (s.seq == s.next_seq - 8'd1) begin
				r.reply = RPL_ACK;
				r.frame_class = CLS_DUP;
			end else begin
				r.reply = RPL_NAK;
				r.frame_class = CLS_ORDER;
				if (s.order_errs != 3'd7)
					s.order_errs++;
			end
			r.file_total = s.total;
			r.error_limit_hit = (s.order_errs >= s.err_limit);
			if (r.frame_class == CLS_EOT)
				clear_session(s);
			clear_frame(s);
		end
		return r;
	endfunction
endpackage

>>> tb/tb_ymodem_frame_receiver.sv
// Self-checking bench for the YMODEM frame receiver.
`default_nettype none
module tb_ymodem_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;
	import ymfr_pkg::*;
	import ymfr_tb_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ymfr_in_if in_ch();
	ymfr_out_if out_ch();
	ymfr_cfg_if cfg();

	ymodem_frame_receiver i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	always #5 clk = ~clk;

	rx_req_t byte_queue[$];
	res_t expected_results[$];
	rx_state_t rx_model;
	int mismatches = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit stim_done = 1'b0;
	bit gaps_on = 1'b1;

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int n;
		n = $urandom_range(0, 99);
		if (!gaps_on || n < 55)
			return 0;
		if (n < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Predict the result of the byte accepted at this edge
	function automatic bit receive_step_push();
		rx_req_t q;
		q.rx_byte = in_ch.rx_byte;
		q.frame_end = in_ch.frame_end;
		expected_results.push_back(receive_byte(rx_model, q));
		return 1'b1;
	endfunction

	// Byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.rx_byte <= '0;
			in_ch.frame_end <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				void'(receive_step_push());
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.rx_byte <= byte_queue[0].rx_byte;
					in_ch.frame_end <= byte_queue[0].frame_end;
					void'(byte_queue.pop_front());
					in_gap <= pick_gap();
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor with random stalls
	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.stage_valid, out_ch.stage_offset, out_ch.stage_byte,
					out_ch.verdict_valid, out_ch.reply, out_ch.frame_class,
					out_ch.commit_len, out_ch.commit_address, out_ch.file_total,
					out_ch.error_limit_hit};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result mismatch exp %h got %h", want, got);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				out_gap <= pick_gap();
			end
		end
	end

	// Watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready) || !arst_n)
			idle_cycles <= 0;
		else if (stim_done || byte_queue.size() > 0 || expected_results.size() > 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == CFG_BASE)
			rx_model.base_addr = val;
		else
			rx_model.err_limit = val[2:0];
	endtask

	task automatic wait_drained();
		while (byte_queue.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic e);
		rx_req_t q;
		q.rx_byte = b;
		q.frame_end = e;
		byte_queue.push_back(q);
	endtask

	// Build a frame; corruption kinds: 0 good, 1 bad crc, 2 bad complement,
	// 3 truncated, 4 overlong
	task automatic push_frame(input bit is_long, input logic [7:0] seq, input int bad,
			input int fill);
		logic [15:0] c;
		int size, n;
		logic [7:0] b;
		c = '0;
		size = is_long ? 1024 : 128;
		n = (bad == 3) ? $urandom_range(3, size + 4) : size + 5;
		push_byte(is_long ? CODE_STX : CODE_SOH, 1'b0);
		push_byte(seq, n == 2);
		push_byte((bad == 2) ? ~seq ^ 8'h10 : ~seq, n == 3);
		for (int i = 0; i < size && 3 + i < n; i++) begin
			b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
			c = crc16_step(c, b);
			push_byte(b, 4 + i == n);
		end
		if (bad == 1)
			c = c ^ (16'h1 << $urandom_range(0, 15));
		if (n >= size + 4)
			push_byte(c[15:8], n == size + 4 && bad != 4);
		if (n >= size + 5)
			push_byte(c[7:0], bad != 4);
		if (bad == 4)
			repeat ($urandom_range(1, 3))
				push_byte(8'($urandom), 1'b0);
		if (bad == 4)
			push_byte(8'($urandom), 1'b1);
	endtask

	task automatic push_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			push_byte(i == 0 ? 8'($urandom_range(5, 255)) : 8'($urandom), i == n - 1);
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = CFG_BASE;
		cfg.data = '0;
		rx_model.base_addr = 24'd4096;
		rx_model.err_limit = 3'd5;
		clear_frame(rx_model);
		clear_session(rx_model);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed session: header, data, duplicate, errors, EOT
		push_frame(0, 8'd0, 0, 0);
		push_frame(0, 8'd1, 0, 1);
		push_frame(0, 8'd1, 0, 2);
		push_frame(0, 8'd9, 0, 2);
		push_frame(0, 8'd2, 1, 2);
		push_frame(0, 8'd2, 2, 2);
		push_frame(0, 8'd2, 3, 2);
		push_frame(0, 8'd2, 4, 2);
		push_noise();
		push_byte(CODE_EOT, 1'b1);
		wait_drained();

		// Second session at register extremes, back to back, address wraps
		write_reg(CFG_BASE, 24'hFFFFFF);
		write_reg(CFG_LIMIT, 24'd0);
		gaps_on = 1'b0;
		push_byte(CODE_EOT, 1'b1);
		push_frame(0, 8'd0, 0, 2);
		push_frame(0, 8'd1, 0, 1);
		push_frame(0, 8'd2, 0, 2);
		stim_done = 1'b1;
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
